// ===== hw/rtl/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the
// Modbus RTU request framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mrf_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned CRC_SPAN    = 6;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] READ_QUANTITY = 16'h0001;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_READ_FC    = 2'd1,
    CFG_WRITE_FC   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } req_mode_t;

  // first six bytes of a frame, in send order from the top
  typedef struct packed {
    logic [7:0] slave;
    logic [7:0] func;
    logic [7:0] reg_hi;
    logic [7:0] reg_lo;
    logic [7:0] word_hi;
    logic [7:0] word_lo;
  } req_frame_t;

  // queue to back end
  typedef struct packed {
    logic       valid;
    req_frame_t frame;
  } frame_q_t;

  // one byte through the reflected CRC, eight bit steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrf_front.sv =====
// ----------------------------------------------------------------------------
// mrf_front
// Holds the configuration registers and turns a request into the six
// header bytes of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_front
  import mrf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_mode,
  input  wire logic [15:0]           in_register_address,
  input  wire logic [15:0]           in_write_value,
  output req_frame_t                 frame
);

  logic [7:0] slave_r;
  logic [7:0] read_fc_r;
  logic [7:0] write_fc_r;
  logic [15:0] word;
  logic        is_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r    <= 8'd1;
      read_fc_r  <= 8'd3;
      write_fc_r <= 8'd6;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SLAVE_ADDR: slave_r    <= cfg_wdata;
        CFG_READ_FC:    read_fc_r  <= cfg_wdata;
        CFG_WRITE_FC:   write_fc_r <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_comb begin
    is_write = (req_mode_t'(in_mode) == MODE_WRITE);
    word     = is_write ? in_write_value : READ_QUANTITY;
    frame.slave   = slave_r;
    frame.func    = is_write ? write_fc_r : read_fc_r;
    frame.reg_hi  = in_register_address[15:8];
    frame.reg_lo  = in_register_address[7:0];
    frame.word_hi = word[15:8];
    frame.word_lo = word[7:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrf_queue.sv =====
// ----------------------------------------------------------------------------
// mrf_queue
// Two-entry queue of frame headers between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_queue
  import mrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire req_frame_t push_frame,
  output logic            full,
  input  wire logic       pop,
  output frame_q_t        head
);

  req_frame_t mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.frame = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrf_back.sv =====
// ----------------------------------------------------------------------------
// mrf_back
// Serialises a frame header a byte at a time, folds each header byte into
// the CRC and appends the CRC low byte then high byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_back
  import mrf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire frame_q_t head,
  output logic          pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);

  logic             busy_r,  busy_nxt;
  logic [IDX_W-1:0] idx_r,   idx_nxt;
  req_frame_t       frame_r, frame_nxt;
  logic [15:0]      crc_r,   crc_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             olast_r, olast_nxt;
  logic             out_free;
  logic             emit;
  logic [7:0]       cur_byte;

  assign out_free = !ovalid_r || !out_stall;
  assign emit     = busy_r && out_free;

  always_comb begin
    unique case (idx_r)
      3'd0:    cur_byte = frame_r.slave;
      3'd1:    cur_byte = frame_r.func;
      3'd2:    cur_byte = frame_r.reg_hi;
      3'd3:    cur_byte = frame_r.reg_lo;
      3'd4:    cur_byte = frame_r.word_hi;
      3'd5:    cur_byte = frame_r.word_lo;
      3'd6:    cur_byte = crc_r[7:0];
      default: cur_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    frame_nxt  = frame_r;
    crc_nxt    = crc_r;
    ovalid_nxt = ovalid_r && out_stall;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    pop        = 1'b0;
    if (emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur_byte;
      olast_nxt  = (idx_r == IDX_W'(FRAME_BYTES - 1));
      if (idx_r < IDX_W'(CRC_SPAN)) crc_nxt = crc16_byte(crc_r, cur_byte);
      if (idx_r == IDX_W'(FRAME_BYTES - 1)) begin
        // last byte out: pick up the next header straight away
        idx_nxt   = '0;
        crc_nxt   = CRC_INIT;
        busy_nxt  = head.valid;
        pop       = head.valid;
        frame_nxt = head.frame;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end else if (!busy_r && head.valid) begin
      pop       = 1'b1;
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      crc_nxt   = CRC_INIT;
      frame_nxt = head.frame;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    crc_r   <= crc_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_tx_byte   = obyte_r;
  assign out_last_byte = olast_r;

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (idx_r == '0))
    else $error("byte index not cleared while idle");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_free) |=> ($stable(idx_r) && $stable(crc_r)))
    else $error("serialiser moved while output stalled");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && idx_r == IDX_W'(FRAME_BYTES - 1)) |=> (idx_r == '0 && out_last_byte))
    else $error("frame end not handled");

endmodule

`default_nettype wire

// ===== hw/rtl/modbus_rtu_request_framer_top.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_top
// Modbus RTU single-register request framer: one request in, eight frame
// bytes out (address, function, register, word, CRC-16/Modbus low first).
//
//   channel  dir  ports                                           handshake
//   in       in   in_mode, in_register_address, in_write_value    valid/stall
//   out      out  out_tx_byte, out_last_byte                      valid/stall
//   cfg      in   cfg_index, cfg_wdata                            cfg_we
//
// One byte per cycle while the output is not stalled, set by the output byte
// serialiser, which loads the next header straight after a frame's last byte.
// A two-word queue lets up to two requests wait behind the one in flight.
// Synchronous active-low reset; configuration returns to 1, 3, 6.
// A stall on the output freezes the serialiser; the input stalls only when
// the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_framer_top
  import mrf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [15:0]           in_register_address,
  input  wire logic [15:0]           in_write_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_tx_byte,
  output logic                       out_last_byte
);

  req_frame_t frame;
  frame_q_t   head;
  logic       q_full;
  logic       q_pop;
  logic       push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  mrf_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_mode             (in_mode),
    .in_register_address (in_register_address),
    .in_write_value      (in_write_value),
    .frame               (frame)
  );

  mrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (frame),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head)
  );

  mrf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

`default_nettype wire
